[design/led_matrix_two_wire_sender_assert.svh]
// assertion helpers for the two-wire led matrix sender
`ifndef LED_MATRIX_TWO_WIRE_SENDER_ASSERT_SVH
`define LED_MATRIX_TWO_WIRE_SENDER_ASSERT_SVH

// same-cycle implication, checked at every clock edge out of reset
`define LMTWS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LMTWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/lmtws_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lmtws_pkg;

  localparam int COLUMNS     = 16;
  localparam int QUEUE_DEPTH = 2;

  // input mode codes
  localparam logic [2:0] MODE_TICK       = 3'd0;
  localparam logic [2:0] MODE_SET_DOT    = 3'd1;
  localparam logic [2:0] MODE_SET_COLUMN = 3'd2;
  localparam logic [2:0] MODE_FLUSH      = 3'd3;
  localparam logic [2:0] MODE_CLEAR      = 3'd4;
  localparam logic [2:0] MODE_LEVEL      = 3'd5;
  localparam logic [2:0] MODE_DIRECT     = 3'd6;

  // register indexes
  localparam logic [2:0] CFG_AUTO_INC    = 3'd0;
  localparam logic [2:0] CFG_FIXED_ADDR  = 3'd1;
  localparam logic [2:0] CFG_ADDR_BASE   = 3'd2;
  localparam logic [2:0] CFG_DISP_ON     = 3'd3;
  localparam logic [2:0] CFG_DISP_OFF    = 3'd4;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_TICK,
    OP_SET_DOT,
    OP_SET_COLUMN,
    OP_FLUSH,
    OP_CLEAR,
    OP_LEVEL,
    OP_DIRECT
  } op_e;

  typedef enum logic [2:0] {
    JOB_IDLE,
    JOB_LEVEL,
    JOB_FLUSH,
    JOB_CLEAR,
    JOB_DIRECT
  } job_e;

  typedef struct packed {
    logic [2:0]        mode;
    logic [3:0]        column;
    logic [2:0]        row;
    logic              dot_on;
    logic [7:0]        line_value;
    logic signed [3:0] level;
  } in_item_t;

  typedef struct packed {
    logic              clk_pin;
    logic              din_pin;
    logic              busy_res;
    logic              rejected;
    logic signed [3:0] brightness_now;
  } out_item_t;

  // classified item as held in the queue
  typedef struct packed {
    op_e               op;
    logic [3:0]        column;
    logic [2:0]        row;
    logic              dot_on;
    logic [7:0]        line_value;
    logic signed [3:0] level;
    logic              col_ok;
  } op_t;

  typedef struct packed {
    logic not_full;
    logic not_empty;
  } q_stat_t;

  typedef struct packed {
    logic       we;
    logic [2:0] index;
    logic [7:0] data;
  } cfg_wr_t;

endpackage

`default_nettype wire

[design/lmtws_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module lmtws_front
  import lmtws_pkg::*;
(
  input  in_item_t item_i,
  output op_t      op_o
);

  always_comb begin
    op_o.column     = item_i.column;
    op_o.row        = item_i.row;
    op_o.dot_on     = item_i.dot_on;
    op_o.line_value = item_i.line_value;
    // any negative level means display off
    op_o.level      = item_i.level[3] ? 4'sb1111 : item_i.level;
    op_o.col_ok     = ({1'b0, item_i.column} < 5'(COLUMNS));
    unique case (item_i.mode)
      MODE_TICK:       op_o.op = OP_TICK;
      MODE_SET_DOT:    op_o.op = OP_SET_DOT;
      MODE_SET_COLUMN: op_o.op = OP_SET_COLUMN;
      MODE_FLUSH:      op_o.op = OP_FLUSH;
      MODE_CLEAR:      op_o.op = OP_CLEAR;
      MODE_LEVEL:      op_o.op = OP_LEVEL;
      MODE_DIRECT:     op_o.op = OP_DIRECT;
      default:         op_o.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

[design/lmtws_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module lmtws_queue
  import lmtws_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  op_t     push_data_i,
  input  logic    pop_i,
  output op_t     pop_data_o,
  output q_stat_t stat_o
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  op_t           mem_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign stat_o.not_full  = (cnt_q != CW'(QUEUE_DEPTH));
  assign stat_o.not_empty = (cnt_q != '0);
  assign do_push          = push_i && stat_o.not_full;
  assign do_pop           = pop_i && stat_o.not_empty;
  assign pop_data_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

[design/lmtws_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module lmtws_back
  import lmtws_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_wr_t   cfg_i,
  input  logic      op_valid_i,
  input  op_t       op_i,
  output logic      op_pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_o
);

  localparam logic [4:0] LAST_FLUSH  = 5'(COLUMNS + 1);
  localparam logic [4:0] LAST_DIRECT = 5'd2;

  // stability pulse: data low, clock low, clock high, data high
  function automatic logic [1:0] stab_pins(input logic [1:0] p, input logic c,
                                           input logic d);
    logic [1:0] r;
    r = {c, d};
    case (p)
      2'd0:    r[0] = 1'b0;
      2'd1:    r[1] = 1'b0;
      2'd2:    r[1] = 1'b1;
      default: r[0] = 1'b1;
    endcase
    return r;
  endfunction

  logic [7:0]        auto_inc_q, fixed_addr_q, addr_base_q, disp_on_q, disp_off_q;
  logic [7:0]        dots_q [16];
  logic [7:0]        dots_d [16];
  job_e              job_q, job_d;
  logic [5:0]        step_q, step_d;
  logic [4:0]        bidx_q, bidx_d;
  logic [1:0]        sub_q, sub_d;
  logic [7:0]        shift_q, shift_d;
  logic              clk_q, clk_d, din_q, din_d;
  logic signed [3:0] level_q, level_d;
  logic [3:0]        dcol_q, dcol_d;
  logic [7:0]        dval_q, dval_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;
  logic              exec;

  assign exec        = op_valid_i && (!out_valid_q || out_ready_i);
  assign op_pop_o    = exec;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    logic       do_bit;
    logic       rej;
    logic [1:0] pins;
    logic [3:0] didx;
    logic [4:0] last;
    logic [7:0] data_byte;
    logic [3:0] acol;

    dots_d      = dots_q;
    job_d       = job_q;
    step_d      = step_q;
    bidx_d      = bidx_q;
    sub_d       = sub_q;
    shift_d     = shift_q;
    clk_d       = clk_q;
    din_d       = din_q;
    level_d     = level_q;
    dcol_d      = dcol_q;
    dval_d      = dval_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    do_bit      = 1'b0;
    rej         = 1'b0;
    pins        = {clk_q, din_q};
    didx        = 4'(bidx_q - 5'd2);
    last        = (job_q == JOB_DIRECT) ? LAST_DIRECT : LAST_FLUSH;
    acol        = (job_q == JOB_DIRECT) ? dcol_q : 4'd0;
    if (job_q == JOB_DIRECT) begin
      data_byte = dval_q;
    end else if (job_q == JOB_CLEAR) begin
      data_byte = 8'd0;
    end else if ({1'b0, didx} < 5'(COLUMNS)) begin
      data_byte = dots_q[didx];
    end else begin
      data_byte = 8'd0;
    end

    if (exec) begin
      unique case (op_i.op)
        OP_TICK: begin
          if (job_q != JOB_IDLE) begin
            if (bidx_q == 5'd0) begin
              // command frame
              if (step_q < 6'd4) begin
                pins = stab_pins(step_q[1:0], clk_q, din_q);
              end else if (step_q == 6'd4) begin
                pins[0] = 1'b0;
              end else if (step_q < 6'd29) begin
                do_bit = 1'b1;
              end else if (step_q == 6'd29) begin
                pins[0] = 1'b1;
              end else begin
                pins = stab_pins(step_q[1:0] - 2'd2, clk_q, din_q);
              end
              if (step_q >= 6'd33) begin
                step_d = 6'd0;
                if (job_q == JOB_LEVEL) begin
                  job_d = JOB_IDLE;
                end else begin
                  bidx_d = 5'd1;
                end
              end else begin
                step_d = step_q + 6'd1;
              end
            end else if (bidx_q == 5'd1) begin
              // address byte
              if (step_q == 6'd0) begin
                pins[0] = 1'b0;
              end else begin
                if (step_q == 6'd1) begin
                  shift_d = addr_base_q | {4'd0, acol};
                end
                do_bit = 1'b1;
              end
              if (step_q >= 6'd24) begin
                bidx_d = 5'd2;
                step_d = 6'd0;
              end else begin
                step_d = step_q + 6'd1;
              end
            end else begin
              // data bytes then closing data edge
              if (step_q < 6'd24) begin
                if (step_q == 6'd0) begin
                  shift_d = data_byte;
                end
                do_bit = 1'b1;
                if (step_q == 6'd23) begin
                  if (bidx_q < last) begin
                    bidx_d = bidx_q + 5'd1;
                    step_d = 6'd0;
                  end else begin
                    step_d = 6'd24;
                  end
                end else begin
                  step_d = step_q + 6'd1;
                end
              end else begin
                pins[0] = 1'b1;
                job_d   = JOB_IDLE;
                step_d  = 6'd0;
                bidx_d  = 5'd0;
              end
            end
          end
        end
        OP_SET_DOT: begin
          if (op_i.col_ok) begin
            dots_d[op_i.column][op_i.row] = op_i.dot_on;
          end
        end
        OP_SET_COLUMN: begin
          if (op_i.col_ok) begin
            dots_d[op_i.column] = op_i.line_value;
          end
        end
        OP_FLUSH, OP_CLEAR, OP_LEVEL, OP_DIRECT: begin
          if (job_q != JOB_IDLE) begin
            rej = 1'b1;
          end else begin
            step_d = 6'd0;
            bidx_d = 5'd0;
            sub_d  = 2'd0;
            case (op_i.op)
              OP_FLUSH: begin
                job_d   = JOB_FLUSH;
                shift_d = auto_inc_q;
              end
              OP_CLEAR: begin
                job_d   = JOB_CLEAR;
                shift_d = auto_inc_q;
              end
              OP_LEVEL: begin
                job_d   = JOB_LEVEL;
                level_d = op_i.level;
                shift_d = op_i.level[3] ? disp_off_q
                                        : (disp_on_q | {4'd0, op_i.level});
              end
              default: begin
                job_d   = JOB_DIRECT;
                dcol_d  = op_i.column;
                dval_d  = op_i.line_value;
                shift_d = fixed_addr_q;
              end
            endcase
          end
        end
        default: begin
        end
      endcase

      // one bit slot: clock low, data bit, clock high and shift
      if (do_bit) begin
        case (sub_q)
          2'd0:    pins[1] = 1'b0;
          2'd1:    pins[0] = shift_d[0];
          default: begin
            pins[1] = 1'b1;
            shift_d = {1'b0, shift_d[7:1]};
          end
        endcase
        sub_d = (sub_q == 2'd2) ? 2'd0 : sub_q + 2'd1;
      end
      clk_d = pins[1];
      din_d = pins[0];

      out_valid_d          = 1'b1;
      out_d.clk_pin        = clk_d;
      out_d.din_pin        = din_d;
      out_d.busy_res       = (job_d != JOB_IDLE);
      out_d.rejected       = rej;
      out_d.brightness_now = level_d;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_q       <= JOB_IDLE;
      step_q      <= '0;
      bidx_q      <= '0;
      sub_q       <= '0;
      shift_q     <= '0;
      clk_q       <= 1'b1;
      din_q       <= 1'b1;
      level_q     <= 4'sb1111;
      dcol_q      <= '0;
      dval_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        dots_q[i] <= '0;
      end
    end else begin
      job_q       <= job_d;
      step_q      <= step_d;
      bidx_q      <= bidx_d;
      sub_q       <= sub_d;
      shift_q     <= shift_d;
      clk_q       <= clk_d;
      din_q       <= din_d;
      level_q     <= level_d;
      dcol_q      <= dcol_d;
      dval_q      <= dval_d;
      out_valid_q <= out_valid_d;
      dots_q      <= dots_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_inc_q   <= 8'h40;
      fixed_addr_q <= 8'h44;
      addr_base_q  <= 8'hC0;
      disp_on_q    <= 8'h88;
      disp_off_q   <= 8'h80;
    end else if (cfg_i.we) begin
      unique case (cfg_i.index)
        CFG_AUTO_INC:   auto_inc_q   <= cfg_i.data;
        CFG_FIXED_ADDR: fixed_addr_q <= cfg_i.data;
        CFG_ADDR_BASE:  addr_base_q  <= cfg_i.data;
        CFG_DISP_ON:    disp_on_q    <= cfg_i.data;
        CFG_DISP_OFF:   disp_off_q   <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[design/led_matrix_two_wire_sender.sv]
// two-wire led matrix sender
// in channel (in_valid_i / in_ready_o / in_i): one item per handshake; mode picks
//   a pin tick, a dot or column write to the 16x8 dot buffer, or a transfer
//   command (flush, clear, brightness, direct write)
// out channel (out_valid_o / out_ready_i / out_o): exactly one result item per
//   input item, in order: pin levels, busy, rejected flag, stored brightness
// each tick item moves the clock or data pin by at most one change; a command
//   arriving while a transfer is running is dropped and flagged
// an input item is held in the queue, then registered in the result register; throughput is
//   one item per cycle while the receiver keeps taking results, set by the execute step of the sequencer
// a 2-entry queue between decode and execute keeps in_ready_o free of any
//   path from out_ready_i; when the receiver stalls the result register holds,
//   the queue fills and in_ready_o drops after two more items
// reset clears the dot buffer, leaves both pins high, sets brightness to off
//   (-1) and loads the command registers with their datasheet values
// cfg_we_i writes register cfg_index_i at once; write only while idle
`timescale 1ns / 1ps
`default_nettype none

`include "led_matrix_two_wire_sender_assert.svh"

module led_matrix_two_wire_sender
  import lmtws_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  // configuration write port
  input  logic      cfg_we_i,
  input  logic [2:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  // item input
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_i,
  // result output
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_o
);

  op_t     front_op;
  op_t     queue_op;
  q_stat_t q_stat;
  logic    pop;
  cfg_wr_t cfg;

  assign cfg.we    = cfg_we_i;
  assign cfg.index = cfg_index_i;
  assign cfg.data  = cfg_data_i;

  // decode and clamp
  lmtws_front u_front (
    .item_i (in_i),
    .op_o   (front_op)
  );

  assign in_ready_o = q_stat.not_full;

  // decouples decode from the pin sequencer
  lmtws_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_data_i (front_op),
    .pop_i       (pop),
    .pop_data_o  (queue_op),
    .stat_o      (q_stat)
  );

  // dot buffer, pin sequencer and result register
  lmtws_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .op_valid_i  (q_stat.not_empty),
    .op_i        (queue_op),
    .op_pop_o    (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  // a dropped command only happens while a transfer is running
  `LMTWS_ASSERT_NOW(a_rej_busy, out_valid_o && out_o.rejected, out_o.busy_res, "rejected while idle")

  // between transfers both lines rest high
  `LMTWS_ASSERT_NOW(a_idle_pins, out_valid_o && !out_o.busy_res, out_o.clk_pin && out_o.din_pin, "idle pins not high")

  // stored brightness is off or 0..7
  `LMTWS_ASSERT_NOW(a_level_rng, out_valid_o, !out_o.brightness_now[3] || out_o.brightness_now == 4'sb1111, "brightness out of range")

  // a queued item always reaches a free result register next cycle
  `LMTWS_ASSERT_NEXT(a_drain, q_stat.not_empty && !out_valid_o, out_valid_o, "queue not drained")

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps

import lmtws_pkg::*;

// shadow of the sender: dot buffer, command registers and pin sequencer,
// one expected result per accepted item
class pin_track_board;
  logic [7:0]        dots [16];
  logic signed [3:0] level_q;
  logic [7:0]        shifter;
  int                step;
  int                byte_no;
  job_e              job;
  logic [3:0]        dcol;
  logic [7:0]        dval;
  logic              clk_q;
  logic              din_q;
  logic [7:0]        reg_auto, reg_fixed, reg_addr, reg_on, reg_off;

  out_item_t expected_pins [$];
  int accepted, useful, dropped, frames, checked, failures;

  function new();
    foreach (dots[i]) dots[i] = 8'h00;
    level_q   = -4'sd1;
    shifter   = 8'h00;
    step      = 0;
    byte_no   = 0;
    job       = JOB_IDLE;
    dcol      = 4'h0;
    dval      = 8'h00;
    clk_q     = 1'b1;
    din_q     = 1'b1;
    reg_auto  = 8'h40;
    reg_fixed = 8'h44;
    reg_addr  = 8'hC0;
    reg_on    = 8'h88;
    reg_off   = 8'h80;
  endfunction

  function void write_reg(logic [2:0] idx, logic [7:0] v);
    case (idx)
      CFG_AUTO_INC:   reg_auto  = v;
      CFG_FIXED_ADDR: reg_fixed = v;
      CFG_ADDR_BASE:  reg_addr  = v;
      CFG_DISP_ON:    reg_on    = v;
      CFG_DISP_OFF:   reg_off   = v;
      default: ;
    endcase
  endfunction

  function bit is_busy();
    return job != JOB_IDLE;
  endfunction

  function int pending();
    return expected_pins.size();
  endfunction

  // start/stop stability pulse, one pin change per phase
  function void pulse_step(int p);
    case (p)
      0: din_q = 1'b0;
      1: clk_q = 1'b0;
      2: clk_q = 1'b1;
      default: din_q = 1'b1;
    endcase
  endfunction

  // clock low, data bit, clock high and shift, lsb first
  function void bit_step(int k);
    case (k % 3)
      0: clk_q = 1'b0;
      1: din_q = shifter[0];
      default: begin
        clk_q   = 1'b1;
        shifter = shifter >> 1;
      end
    endcase
  endfunction

  function void end_job();
    job     = JOB_IDLE;
    step    = 0;
    byte_no = 0;
    frames++;
  endfunction

  // a flush reads the column only when its byte starts
  function logic [7:0] data_for_byte();
    if (job == JOB_DIRECT) return dval;
    if (job == JOB_CLEAR) return 8'h00;
    return dots[(byte_no - 2) & 15];
  endfunction

  function void tick();
    int s;
    int last;
    s = step;
    if (job == JOB_IDLE) return;
    if (byte_no == 0) begin
      // command frame
      if (s < 4) pulse_step(s);
      else if (s == 4) din_q = 1'b0;
      else if (s < 29) bit_step(s - 5);
      else if (s == 29) din_q = 1'b1;
      else pulse_step((s - 30) & 3);
      if (s >= 33) begin
        if (job == JOB_LEVEL) end_job();
        else begin
          byte_no = 1;
          step    = 0;
        end
      end else step = s + 1;
    end else if (byte_no == 1) begin
      // address byte
      if (s == 0) din_q = 1'b0;
      else begin
        if (s == 1) shifter = reg_addr | ((job == JOB_DIRECT) ? {4'h0, dcol} : 8'h00);
        bit_step(s - 1);
      end
      if (s >= 24) begin
        byte_no = 2;
        step    = 0;
      end else step = s + 1;
    end else begin
      // data bytes, then release data high
      last = (job == JOB_DIRECT) ? 2 : 1 + COLUMNS;
      if (s < 24) begin
        if (s == 0) shifter = data_for_byte();
        bit_step(s);
        if (s == 23) begin
          if (byte_no < last) begin
            byte_no++;
            step = 0;
          end else step = 24;
        end else step = s + 1;
      end else begin
        din_q = 1'b1;
        end_job();
      end
    end
  endfunction

  function void note_item(in_item_t it);
    out_item_t want;
    bit        busy_now;
    bit        rej;
    busy_now = is_busy();
    rej      = 1'b0;
    accepted++;
    if (it.mode <= MODE_DIRECT && !(it.mode == MODE_TICK && !busy_now)) useful++;
    case (it.mode)
      MODE_TICK: tick();
      MODE_SET_DOT:
        if (it.column < COLUMNS) dots[it.column][it.row] = it.dot_on;
      MODE_SET_COLUMN:
        if (it.column < COLUMNS) dots[it.column] = it.line_value;
      MODE_FLUSH, MODE_CLEAR, MODE_LEVEL, MODE_DIRECT:
        if (busy_now) begin
          rej = 1'b1;
          dropped++;
        end else begin
          step    = 0;
          byte_no = 0;
          case (it.mode)
            MODE_FLUSH: begin
              job     = JOB_FLUSH;
              shifter = reg_auto;
            end
            MODE_CLEAR: begin
              job     = JOB_CLEAR;
              shifter = reg_auto;
            end
            MODE_LEVEL: begin
              // any negative request clamps to display off
              level_q = it.level[3] ? -4'sd1 : it.level;
              job     = JOB_LEVEL;
              shifter = level_q[3] ? reg_off : (reg_on | {5'b0, level_q[2:0]});
            end
            default: begin
              job     = JOB_DIRECT;
              dcol    = it.column;
              dval    = it.line_value;
              shifter = reg_fixed;
            end
          endcase
        end
      default: ;
    endcase
    want.clk_pin        = clk_q;
    want.din_pin        = din_q;
    want.busy_res       = is_busy();
    want.rejected       = rej;
    want.brightness_now = level_q;
    expected_pins.push_back(want);
  endfunction

  function void compare(string field, logic signed [3:0] want, logic signed [3:0] got);
    if (got !== want) begin
      failures++;
      $error("%s: expected %0d, got %0d", field, want, got);
    end
  endfunction

  function void check_pins(out_item_t got);
    out_item_t want;
    if (expected_pins.size() == 0) begin
      failures++;
      $error("result with nothing expected: %h", got);
      return;
    end
    want = expected_pins.pop_front();
    checked++;
    compare("clk_pin", want.clk_pin, got.clk_pin);
    compare("din_pin", want.din_pin, got.din_pin);
    compare("busy_res", want.busy_res, got.busy_res);
    compare("rejected", want.rejected, got.rejected);
    compare("brightness_now", want.brightness_now, got.brightness_now);
  endfunction
endclass

module testbench;
  import lmtws_pkg::*;

  // cycles with no handshake at all before the run is declared hung
  localparam int STALL_LIMIT = 1000;
  // accepted items at which the random part ends; the directed flush alone
  // takes most of them
  localparam int ITEM_TARGET = 580;
  // items between reprogramming passes
  localparam int PHASE_SPAN  = 35;

  logic       clk_i = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_index = CFG_AUTO_INC;
  logic [7:0] cfg_data = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_bus = '0;
  logic       out_valid;
  logic       rx_ready = 1'b0;
  out_item_t  out_bus;

  pin_track_board board;
  bit  quiet = 1'b1;   // no idling on either side
  bit  gappy = 1'b0;   // sender may leave gaps
  int  phases = 0;
  int  hung = 0;

  led_matrix_two_wire_sender uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_i       (in_bus),
    .out_valid_o(out_valid),
    .out_ready_i(rx_ready),
    .out_o      (out_bus)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // every accepted result is checked against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_n && out_valid && rx_ready) board.check_pins(out_bus);
  end

  // receiver: mostly ready, with occasional stall bursts
  initial begin
    forever begin
      @(posedge clk_i);
      if (!quiet && $urandom_range(0, 9) == 0) begin
        rx_ready <= 1'b0;
        repeat ($urandom_range(1, 16) - 1) @(posedge clk_i);
      end else begin
        rx_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && rx_ready)) hung <= 0;
      else hung <= hung + 1;
      if (hung >= STALL_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic in_item_t shape(logic [2:0] mode, logic [3:0] col, logic [2:0] row,
                                     logic dot, logic [7:0] line, logic signed [3:0] lvl);
    in_item_t it;
    it.mode       = mode;
    it.column     = col;
    it.row        = row;
    it.dot_on     = dot;
    it.line_value = line;
    it.level      = lvl;
    return it;
  endfunction

  // random content in every field, mode forced
  function automatic in_item_t any_item(logic [2:0] mode);
    in_item_t it;
    it      = in_item_t'(23'($urandom));
    it.mode = mode;
    return it;
  endfunction

  // hold valid (and the payload) until the item is taken
  task automatic send(in_item_t it);
    if (gappy && !quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_bus   <= it;
    do @(posedge clk_i); while (!in_ready);
    board.note_item(it);
  endtask

  // sender pauses until every expected result is back, then the pipe drains
  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_reg(logic [2:0] idx, logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk_i);
    board.write_reg(idx, v);
  endtask

  // first pass all zeros, second all ones, then random codes
  function automatic logic [7:0] reg_value(int phase);
    if (phase == 1) return 8'h00;
    if (phase == 2) return 8'hFF;
    return 8'($urandom);
  endfunction

  task automatic reprogram(int phase);
    set_reg(CFG_AUTO_INC, reg_value(phase));
    set_reg(CFG_FIXED_ADDR, reg_value(phase));
    set_reg(CFG_ADDR_BASE, reg_value(phase));
    set_reg(CFG_DISP_ON, reg_value(phase));
    set_reg(CFG_DISP_OFF, reg_value(phase));
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // tick the running transfer out, with buffer writes, dropped commands and
  // junk items mixed in
  task automatic drain_job();
    int r;
    while (board.is_busy()) begin
      r = $urandom_range(0, 99);
      if (r < 90) send(any_item(MODE_TICK));
      else if (r < 95) send(any_item(MODE_SET_DOT));
      else if (r < 97) send(any_item(MODE_SET_COLUMN));
      else if (r < 99) send(any_item(3'($urandom_range(MODE_FLUSH, MODE_DIRECT))));
      else send(any_item(3'd7));
    end
  endtask

  // short transfers only: a whole-buffer job takes most of the item budget
  task automatic run_job();
    int r;
    logic [2:0] kind;
    r = $urandom_range(0, 99);
    if (r < 50) kind = MODE_LEVEL;
    else kind = MODE_DIRECT;
    // some noise while idle: idle ticks, unused mode, buffer writes
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        r = $urandom_range(0, 3);
        case (r)
          0: send(any_item(MODE_TICK));
          1: send(any_item(3'd7));
          2: send(any_item(MODE_SET_DOT));
          default: send(any_item(MODE_SET_COLUMN));
        endcase
      end
    end
    send(any_item(kind));
    drain_job();
  endtask

  initial begin
    int next_phase;
    board = new();
    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;

    // directed: idle tick, unused mode, buffer extremes
    send(shape(MODE_TICK, 4'h0, 3'd0, 1'b0, 8'h00, 4'sd0));
    send(shape(3'd7, 4'hF, 3'd7, 1'b1, 8'hFF, -4'sd1));
    send(shape(MODE_SET_DOT, 4'h0, 3'd0, 1'b1, 8'h00, 4'sd0));
    send(shape(MODE_SET_DOT, 4'hF, 3'd7, 1'b1, 8'h00, 4'sd0));
    send(shape(MODE_SET_DOT, 4'hF, 3'd7, 1'b0, 8'hFF, 4'sd0));
    send(shape(MODE_SET_DOT, 4'hF, 3'd7, 1'b1, 8'h00, 4'sd0));
    send(shape(MODE_SET_COLUMN, 4'h1, 3'd0, 1'b0, 8'hFF, 4'sd0));
    send(shape(MODE_SET_COLUMN, 4'h2, 3'd0, 1'b0, 8'h00, 4'sd0));
    send(shape(MODE_SET_COLUMN, 4'hE, 3'd0, 1'b0, 8'hA5, 4'sd0));
    // flush starts; every transfer command is dropped while it runs
    send(shape(MODE_FLUSH, 4'h0, 3'd0, 1'b0, 8'h00, 4'sd0));
    send(shape(MODE_CLEAR, 4'h0, 3'd0, 1'b0, 8'h00, 4'sd0));
    send(shape(MODE_LEVEL, 4'h0, 3'd0, 1'b0, 8'h00, 4'sd7));
    send(shape(MODE_LEVEL, 4'h0, 3'd0, 1'b0, 8'h00, -4'sd8));
    send(shape(MODE_DIRECT, 4'hF, 3'd7, 1'b1, 8'hFF, 4'sd0));
    send(shape(MODE_FLUSH, 4'h0, 3'd0, 1'b0, 8'h00, 4'sd0));
    repeat (5) send(shape(MODE_TICK, 4'h0, 3'd0, 1'b0, 8'h00, 4'sd0));
    // column 0 rewritten before its byte goes out
    send(shape(MODE_SET_COLUMN, 4'h0, 3'd0, 1'b0, 8'h5A, 4'sd0));
    send(shape(MODE_TICK, 4'h0, 3'd0, 1'b0, 8'h00, 4'sd0));

    // random part: idling on, finish the flush, then whole transfers
    quiet = 1'b0;
    gappy = 1'b1;
    drain_job();
    next_phase = board.accepted;
    while (board.accepted < ITEM_TARGET) begin
      if (board.accepted >= next_phase) begin
        settle();
        phases++;
        reprogram(phases);
        next_phase = board.accepted + PHASE_SPAN;
      end
      quiet = (board.accepted >= ITEM_TARGET - 60);
      gappy = ($urandom_range(0, 3) != 0);
      run_job();
    end

    // wind down
    quiet = 1'b1;
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("%0d items sent, %0d of them ignored; %0d commands dropped while busy",
             board.accepted, board.accepted - board.useful, board.dropped);
    $display("%0d frames finished over %0d register settings, %0d results checked",
             board.frames, phases + 1, board.checked);
    if (board.failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
